// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/wddg_pkg.sv =====
// ---------------------------------------------------------------------------
// wddg_pkg
// Shared constants and types of the decision-directed Wiener gain block.
// ---------------------------------------------------------------------------
package wddg_pkg;

  localparam int FFT_MAX_SIZE = 4096;
  localparam int BIN_DEPTH    = FFT_MAX_SIZE / 2 + 1;
  localparam int IDX_W        = $clog2(BIN_DEPTH);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(BIN_DEPTH - 1);

  localparam logic [15:0] SMOOTH_RST = 16'd64225;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 16;

  // pipeline stage numbers of the back end
  localparam int ST_D1   = 0;
  localparam int ST_POST = ST_D1 + DIV_STEPS + 1;
  localparam int ST_CUR  = ST_POST + 1;
  localparam int ST_T    = ST_CUR + 1;
  localparam int ST_AT   = ST_T + 1;
  localparam int ST_PRI  = ST_AT + 1;
  localparam int ST_D2   = ST_PRI + 1;
  localparam int ST_SQ   = ST_D2 + DIV_STEPS + 1;
  localparam int ST_LAST = ST_SQ + SQRT_STEPS;
  localparam int NSTG    = ST_LAST + 1;

  localparam int MEM_W = 48;

  typedef struct packed {
    logic [31:0]      sig;
    logic [31:0]      noi;
    logic             last;
    logic             first;
    logic [IDX_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic             last;
    logic             first;
    logic [IDX_W-1:0] idx;
  } ctl_t;

endpackage

// ===== rtl/core/wddg_ram.sv =====
// ---------------------------------------------------------------------------
// wddg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wddg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/wddg_front.sv =====
// ---------------------------------------------------------------------------
// wddg_front
// Accepts bins, numbers them within the frame and tags first-frame bins.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wddg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic                in_tlast,
  output logic                push,
  output wddg_pkg::item_t     push_item,
  input  logic                q_ready
);

  logic [wddg_pkg::IDX_W-1:0] bin_index_r, bin_index_nxt;
  logic                       first_frame_r, first_frame_nxt;

  assign in_tready = q_ready;
  assign push      = in_tvalid && q_ready;

  always_comb begin
    push_item.sig   = in_tdata[31:0];
    push_item.noi   = in_tdata[63:32];
    push_item.last  = in_tlast;
    push_item.first = first_frame_r;
    push_item.idx   = bin_index_r;
  end

  always_comb begin
    bin_index_nxt   = bin_index_r;
    first_frame_nxt = first_frame_r;
    if (push) begin
      if (in_tlast) begin
        bin_index_nxt   = '0;
        first_frame_nxt = 1'b0;
      end else if (bin_index_r != wddg_pkg::IDX_MAX) begin
        bin_index_nxt = bin_index_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_index_r   <= '0;
      first_frame_r <= 1'b1;
    end else begin
      bin_index_r   <= bin_index_nxt;
      first_frame_r <= first_frame_nxt;
    end
  end

  `ASSERT_NEXT(a_first_drops_on_last, first_frame_r && !(push && in_tlast), first_frame_r)
  `ASSERT_ALWAYS(a_index_in_range, bin_index_r <= wddg_pkg::IDX_MAX)
  `ASSERT_NEXT(a_index_restart, push && in_tlast, bin_index_r == '0)

endmodule

// ===== rtl/core/wddg_queue.sv =====
// ---------------------------------------------------------------------------
// wddg_queue
// Short word queue between the front and the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wddg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wddg_pkg::item_t push_item,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output wddg_pkg::item_t q_head
);

  wddg_pkg::item_t                  ent_r [wddg_pkg::Q_DEPTH];
  logic [wddg_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [wddg_pkg::Q_CNT_W-1:0]     count_r, count_nxt;

  assign q_ready = count_r != wddg_pkg::Q_CNT_W'(wddg_pkg::Q_DEPTH);
  assign q_valid = count_r != '0;
  assign q_head  = ent_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count_r <= wddg_pkg::Q_CNT_W'(wddg_pkg::Q_DEPTH))
  `ASSERT_IMPLIES(a_pop_nonempty, pop, count_r != '0)

endmodule

// ===== rtl/core/wddg_back.sv =====
// ---------------------------------------------------------------------------
// wddg_back
// Gain pipeline: SNR divider, decision-directed update, Wiener gain
// divider and square root, per-bin history RAM and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wddg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  logic            q_valid,
  input  wddg_pkg::item_t q_head,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  output logic            out_tlast
);

  localparam int NSTG = wddg_pkg::NSTG;
  localparam int DS   = wddg_pkg::DIV_STEPS;
  localparam int SS   = wddg_pkg::SQRT_STEPS;

  logic [15:0] smooth_r;

  logic            vld_r [NSTG];
  wddg_pkg::ctl_t  ctl_r [NSTG];
  logic            adv;
  logic            hazard;

  // SNR divider
  logic [31:0] d1_rem [DS+1];
  logic [31:0] d1_quo [DS+1];
  logic [31:0] d1_dvd [DS+1];
  logic [31:0] d1_noi [DS+1];
  logic        d1_zero [DS+1];
  logic        d1_sat  [DS+1];

  logic [31:0] post_r [wddg_pkg::ST_POST:wddg_pkg::ST_LAST];
  logic [31:0] pp_r;
  logic [31:0] cur_r [wddg_pkg::ST_CUR:wddg_pkg::ST_AT];
  logic [15:0] g2_r;
  logic [31:0] pprev_r;
  logic [31:0] t_r;
  logic [31:0] at_r;
  logic [31:0] pri_r;

  // gain divider and root
  logic [32:0] d2_rem [DS+1];
  logic [31:0] d2_quo [DS+1];
  logic [32:0] d2_den [DS+1];
  logic [31:0] sq_src  [SS+1];
  logic [17:0] sq_rem  [SS+1];
  logic [15:0] sq_root [SS+1];

  logic                        ram_we, ram_re;
  logic [wddg_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [wddg_pkg::MEM_W-1:0]  ram_wdata, ram_rdata;

  logic        out_vld_r;
  logic [15:0] out_gain_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= wddg_pkg::SMOOTH_RST;
    end else if (cfg_we) begin
      smooth_r <= cfg_wdata;
    end
  end

  assign adv = !out_vld_r || out_tready;

  // hold a bin until the previous frame's write of the same bin has left the pipe
  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s < NSTG; s++) begin
      if (vld_r[s] && ctl_r[s].idx == q_head.idx) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && !q_head.first;
  end

  assign pop = q_valid && adv && !hazard;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= pop;
      for (int s = 1; s < NSTG; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0].last  <= q_head.last;
      ctl_r[0].first <= q_head.first;
      ctl_r[0].idx   <= q_head.idx;
      for (int s = 1; s < NSTG; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
    end
  end

  // SNR divider load: quotient fits 32 bits unless it saturates
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_rem[0]  <= {16'd0, q_head.sig[31:16]};
      d1_quo[0]  <= '0;
      d1_dvd[0]  <= {q_head.sig[15:0], 16'd0};
      d1_noi[0]  <= q_head.noi;
      d1_zero[0] <= q_head.noi == '0;
      d1_sat[0]  <= (q_head.noi[31:16] == '0) &&
                    (q_head.sig >= {q_head.noi[15:0], 16'd0});
    end
  end

  for (genvar k = 1; k <= DS; k++) begin : g_div1
    logic [32:0] t;
    logic        ge;
    assign t  = {d1_rem[k-1], d1_dvd[k-1][31]};
    assign ge = t >= {1'b0, d1_noi[k-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        d1_rem[k]  <= ge ? 32'(t - {1'b0, d1_noi[k-1]}) : t[31:0];
        d1_quo[k]  <= {d1_quo[k-1][30:0], ge};
        d1_dvd[k]  <= {d1_dvd[k-1][30:0], 1'b0};
        d1_noi[k]  <= d1_noi[k-1];
        d1_zero[k] <= d1_zero[k-1];
        d1_sat[k]  <= d1_sat[k-1];
      end
    end
  end

  logic [31:0] post_c;
  always_comb begin
    priority if (d1_zero[DS]) begin
      post_c = '0;
    end else if (d1_sat[DS]) begin
      post_c = '1;
    end else begin
      post_c = d1_quo[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      post_r[wddg_pkg::ST_POST] <= post_c;
      pp_r <= (post_c[31:16] != '0) ? (post_c - 32'h0001_0000) : '0;
      for (int s = wddg_pkg::ST_POST + 1; s <= wddg_pkg::ST_LAST; s++) begin
        post_r[s] <= post_r[s-1];
      end
    end
  end

  // history read issued as a bin enters the post stage
  assign ram_raddr = ctl_r[wddg_pkg::ST_POST-1].idx;
  assign ram_re    = adv && vld_r[wddg_pkg::ST_POST-1] && !ctl_r[wddg_pkg::ST_POST-1].first;

  logic [16:0] wcur;
  logic [48:0] cur_prod;
  logic [31:0] g2_prod;
  logic [47:0] t_prod;
  logic [47:0] at_prod;
  logic [32:0] pri_sum;

  assign wcur     = 17'h1_0000 - {1'b0, smooth_r};
  assign cur_prod = {32'd0, wcur} * {17'd0, pp_r};
  assign g2_prod  = {16'd0, ram_rdata[15:0]} * {16'd0, ram_rdata[15:0]};
  assign t_prod   = {32'd0, g2_r} * {16'd0, pprev_r};
  assign at_prod  = {32'd0, smooth_r} * {16'd0, t_r};
  assign pri_sum  = ctl_r[wddg_pkg::ST_AT].first ?
                    ({17'd0, smooth_r} + {1'b0, cur_r[wddg_pkg::ST_AT]}) :
                    ({1'b0, at_r} + {1'b0, cur_r[wddg_pkg::ST_AT]});

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_r[wddg_pkg::ST_CUR] <= cur_prod[47:16];
      g2_r                    <= g2_prod[31:16];
      pprev_r                 <= ram_rdata[47:16];
      cur_r[wddg_pkg::ST_T]   <= cur_r[wddg_pkg::ST_CUR];
      t_r                     <= t_prod[47:16];
      cur_r[wddg_pkg::ST_AT]  <= cur_r[wddg_pkg::ST_T];
      at_r                    <= at_prod[47:16];
      pri_r                   <= pri_sum[32] ? '1 : pri_sum[31:0];
    end
  end

  // gain divider: floor((2^48 - 1) / (pri + 1.0)), dividend bits all ones
  always_ff @(posedge clk) begin
    if (adv) begin
      d2_rem[0] <= 33'h0_0000_FFFF;
      d2_quo[0] <= '0;
      d2_den[0] <= {1'b0, pri_r} + 33'h0_0001_0000;
    end
  end

  for (genvar k = 1; k <= DS; k++) begin : g_div2
    logic [33:0] t;
    logic        ge;
    assign t  = {d2_rem[k-1], 1'b1};
    assign ge = t >= {1'b0, d2_den[k-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        d2_rem[k] <= ge ? 33'(t - {1'b0, d2_den[k-1]}) : t[32:0];
        d2_quo[k] <= {d2_quo[k-1][30:0], ge};
        d2_den[k] <= d2_den[k-1];
      end
    end
  end

  // radicand 2^32 - ceil(2^48 / d)
  logic [32:0] x_ceil;
  logic [32:0] rad;
  assign x_ceil = {1'b0, d2_quo[DS]} + 33'd1;
  assign rad    = 33'h1_0000_0000 - x_ceil;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_src[0]  <= rad[31:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar k = 1; k <= SS; k++) begin : g_sqrt
    logic [19:0] rv;
    logic [19:0] trial;
    logic        ge;
    assign rv    = {sq_rem[k-1], sq_src[k-1][31:30]};
    assign trial = {2'b00, sq_root[k-1], 2'b01};
    assign ge    = rv >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k]  <= ge ? 18'(rv - trial) : rv[17:0];
        sq_root[k] <= {sq_root[k-1][14:0], ge};
        sq_src[k]  <= {sq_src[k-1][29:0], 2'b00};
      end
    end
  end

  assign ram_we    = adv && vld_r[wddg_pkg::ST_LAST];
  assign ram_waddr = ctl_r[wddg_pkg::ST_LAST].idx;
  assign ram_wdata = {post_r[wddg_pkg::ST_LAST], sq_root[SS]};

  wddg_ram #(
    .WIDTH (wddg_pkg::MEM_W),
    .DEPTH (wddg_pkg::BIN_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[wddg_pkg::ST_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_gain_r <= sq_root[SS];
      out_last_r <= ctl_r[wddg_pkg::ST_LAST].last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_gain_r;
  assign out_tlast  = out_last_r;

  `ASSERT_IMPLIES(a_no_rw_same_bin, ram_we && ram_re, ram_waddr != ram_raddr)
  `ASSERT_NEXT(a_out_hold, out_vld_r && !out_tready, out_vld_r)

endmodule

// ===== rtl/core/wiener_decision_directed_gain_top.sv =====
// ---------------------------------------------------------------------------
// wiener_decision_directed_gain_top
// Per-bin Wiener gain from the decision-directed a priori SNR.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tdata signal, noise; tlast last bin
//  out_    | out | out_tvalid / out_tready| tdata gain Q0.16; tlast frame end
//  cfg_    | in  | cfg_we                 | cfg_wdata smoothing factor Q0.16
//
//  One word per cycle sustained while out_tready is high and no bin waits;
//  the back pipe holds the two 32-step dividers and the 16-step root.
//  A bin waits in the queue while the same bin of the previous frame is still
//  in the pipe, so frames shorter than the pipe depth run slower.
//  out_tready low stalls the whole back pipe; the front keeps taking words
//  until the four-entry queue is full. Reset is synchronous, active low.
// ---------------------------------------------------------------------------
module wiener_decision_directed_gain_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] signal_power, [63:32] noise_power
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] gain
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic            push, q_ready, q_valid, pop;
  wddg_pkg::item_t push_item, q_head;

  wddg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  wddg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_head    (q_head)
  );

  wddg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== verif/wiener_decision_directed_gain_top_tb.sv =====
// ---------------------------------------------------------------------------
// wiener_decision_directed_gain_top_tb
// Streams frequency bins into the Wiener gain block, predicts each bin's gain
// from its own copy of the per-bin history, and checks every output word in
// order. The first frame is at least as long as any later one so that no
// later frame reaches a bin that was never written. Later phases use several
// smoothing factors, random gaps on both sides and one long output stall.
// ---------------------------------------------------------------------------
module wiener_decision_directed_gain_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE      = 120;
  localparam int FIRST_RAND  = 87;
  localparam int HOLD_AFTER  = 110;

  // Per-bin gain predictor and the queue of gains it expects.
  class gain_scoreboard;
    logic [31:0] hist_post [wddg_pkg::BIN_DEPTH];
    logic [15:0] hist_gain [wddg_pkg::BIN_DEPTH];
    bit          in_first_frame;
    int unsigned bin_pos;
    logic [15:0] smoothing;
    logic [15:0] gain_q [$];
    bit          last_q [$];
    int          mismatches;
    int          checked;

    function new();
      in_first_frame = 1;
      bin_pos        = 0;
      smoothing      = wddg_pkg::SMOOTH_RST;
      mismatches     = 0;
      checked        = 0;
    endfunction

    function void set_smoothing(logic [15:0] a);
      smoothing = a;
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[31:0];
    endfunction

    function automatic logic [15:0] gain_of(logic [31:0] pri);
      logic [63:0] d;
      logic [63:0] x;
      logic [31:0] g;
      d = 64'(pri) + 64'd65536;
      x = ((64'd1 << 48) + d - 1) / d;
      g = int_sqrt((64'd1 << 32) - x);
      return (g > 32'd65535) ? 16'hFFFF : g[15:0];
    endfunction

    function void note_input(logic [31:0] sig, logic [31:0] noi, bit last);
      logic [63:0] post, pp, cur, pri, g2, t, a;
      int unsigned idx;
      logic [15:0] g;
      idx = (bin_pos < wddg_pkg::BIN_DEPTH - 1) ? bin_pos : wddg_pkg::BIN_DEPTH - 1;
      a   = 64'(smoothing);
      if (noi == 0) begin
        post = 0;
      end else begin
        post = (64'(sig) << 16) / 64'(noi);
        if (post > 64'hFFFF_FFFF) post = 64'hFFFF_FFFF;
      end
      pp  = (post >= 64'd65536) ? post - 64'd65536 : 0;
      cur = ((64'd65536 - a) * pp) >> 16;
      if (in_first_frame) begin
        pri = a + cur;
      end else begin
        g2  = (64'(hist_gain[idx]) * 64'(hist_gain[idx])) >> 16;
        t   = (g2 * 64'(hist_post[idx])) >> 16;
        pri = ((a * t) >> 16) + cur;
      end
      if (pri > 64'hFFFF_FFFF) pri = 64'hFFFF_FFFF;
      g = gain_of(pri[31:0]);
      hist_post[idx] = post[31:0];
      hist_gain[idx] = g;
      if (last) begin
        in_first_frame = 0;
        bin_pos        = 0;
      end else if (bin_pos < wddg_pkg::BIN_DEPTH - 1) begin
        bin_pos++;
      end
      gain_q.push_back(g);
      last_q.push_back(last);
    endfunction

    function void check_result(logic [15:0] gain, logic last);
      logic [15:0] eg;
      bit          el;
      checked++;
      if (gain_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word gain=%h last=%b", $realtime, gain, last);
        return;
      end
      eg = gain_q.pop_front();
      el = last_q.pop_front();
      if (gain !== eg || last !== el) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word %0d gain exp %h got %h, last exp %b got %b",
                   $realtime, checked, eg, gain, el, last);
      end
    endfunction

    function int pending();
      return gain_q.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 0;
  logic [15:0] cfg_wdata = '0;

  gain_scoreboard sb = new();
  bit          steady_phase = 0;
  int          idle_cycles = 0;
  int          words_in = 0;
  int          frames_in = 0;

  always #5 clk = ~clk;

  wiener_decision_directed_gain_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int pick_gap();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Output side: random stalls, plus one long hold once traffic is flowing.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_tready = 0;
        hold--;
      end else begin
        out_tready = (pick_gap() == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("watchdog: no progress, %0d words pending", sb.pending());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_bin(logic [31:0] sig, logic [31:0] noi, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata  = {noi, sig};
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(sig, noi, last);
    words_in++;
    if (last) frames_in++;
    @(negedge clk);
  endtask

  task automatic rand_bin(bit last);
    logic [31:0] s, n;
    s = $urandom();
    case ($urandom_range(5))
      0: n = $urandom();
      1: n = 0;
      2: n = (s >> $urandom_range(20)) | 32'($urandom_range(1));
      3: n = s << $urandom_range(4);
      4: begin s = $urandom_range(65535); n = $urandom_range(65535); end
      default: begin
        s = $urandom_range(1) ? 32'hFFFF_FFFF : 0;
        n = $urandom_range(1) ? 32'hFFFF_FFFF : 32'($urandom_range(2));
      end
    endcase
    send_bin(s, n, last);
  endtask

  // Frames never run longer than the first one.
  task automatic send_frames(int n_words);
    int len, sent;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(19))
        0:       len = $urandom_range(100, 61);
        1, 2, 3: len = $urandom_range(60, 17);
        default: len = $urandom_range(16, 1);
      endcase
      for (int i = 0; i < len; i++) rand_bin(i == len - 1);
      sent += len;
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Let the pipe drain, then write the register while nothing is in flight.
  task automatic write_smoothing(logic [15:0] a);
    in_tvalid = 0;
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1;
    cfg_wdata = a;
    @(negedge clk);
    cfg_we = 0;
    sb.set_smoothing(a);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // First frame, reset smoothing: field extremes and zero noise, then
    // random bins up to the longest frame length used later.
    send_bin(0, 0, 0);
    send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_bin(32'hFFFF_FFFF, 1, 0);
    send_bin(32'hFFFF_FFFF, 0, 0);
    send_bin(1, 0, 0);
    send_bin(0, 1, 0);
    send_bin(1, 32'hFFFF_FFFF, 0);
    send_bin(65536, 65536, 0);
    send_bin(2, 1, 0);
    send_bin(3, 2, 0);
    send_bin(32'h8000_0000, 32'h0000_8000, 0);
    send_bin(32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_bin(32'hAAAA_AAAA, 32'h5555_5555, 0);
    for (int i = 0; i < FIRST_RAND; i++) rand_bin(i == FIRST_RAND - 1);
    send_frames(120);

    write_smoothing(16'd0);
    send_frames(80);
    write_smoothing(16'hFFFF);
    steady_phase = 1;
    send_frames(80);
    steady_phase = 0;
    write_smoothing(16'($urandom()));
    send_frames(80);
    write_smoothing(wddg_pkg::SMOOTH_RST);
    send_frames(80);

    in_tvalid = 0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d bins in %0d frames over five smoothing settings, %0d words checked.",
             words_in, frames_in, sb.checked);
    $display("Covered zero noise, saturation, short frames and a long stall.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/wddg_pkg.sv
rtl/core/wddg_ram.sv
rtl/core/wddg_front.sv
rtl/core/wddg_queue.sv
rtl/core/wddg_back.sv
rtl/core/wiener_decision_directed_gain_top.sv
verif/wiener_decision_directed_gain_top_tb.sv
